@@ rtl/rail_fence_zigzag_reorder_assert.svh @@
// Assertion macros used by the rail fence reorder module.
`ifndef RAIL_FENCE_ZIGZAG_REORDER_ASSERT_SVH
`define RAIL_FENCE_ZIGZAG_REORDER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define RFZR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk_i outside reset.
`define RFZR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rfzr_pkg.sv @@
// Package with widths shared by the rail fence reorder RTL and its bench.
`timescale 1ns / 1ps

package rfzr_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned RowsW   = 7;
  localparam int unsigned StrideW = 8;

  typedef logic [CharW-1:0]   char_t;
  typedef logic [RowsW-1:0]   rows_t;
  typedef logic [StrideW-1:0] stride_t;

endpackage

@@ rtl/rail_fence_zigzag_reorder.sv @@
// Rail fence (zigzag) reordering of a byte string held in a local RAM.
// The slave stream carries one byte per request in tdata and marks the final
// byte of a string with tlast. Bytes are written into a RAM of MAX_LEN
// entries, one per cycle, with tready high while the block is loading.
// Bytes past MAX_LEN are dropped and the string is marked as overflowed.
// After the final byte the block stops taking requests and reads the string
// back in zigzag order over num_rows rows; one row, or fewer bytes than
// rows, gives the string unchanged. The master stream carries one byte per
// request with tlast on the final byte and the overflow flag in tuser.
// After the final byte is accepted, StRead issues the first RAM read and
// the first result is then valid in StSend. Each result passes through
// StRead, which steps the position through the adder and issues the RAM
// read, and then StSend, which presents the registered data. A stalled
// receiver simply holds the result and the sequencer waits. Reset empties
// the buffer and sets num_rows to one; the RAM needs no clearing since only
// bytes of the current string are read. The user must write num_rows
// through cfg_we_i and cfg_wdata_i while idle; the block does not enforce it.
`timescale 1ns / 1ps

module rail_fence_zigzag_reorder #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] in_char
  input  logic                 s_axis_tlast,   // in_last
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_char
  output logic                 m_axis_tlast,   // out_last
  output logic                 m_axis_tuser    // [0] overflow
);

  `include "rail_fence_zigzag_reorder_assert.svh"

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned JW = $clog2(MAX_LEN + 256);

  typedef enum logic [1:0] {
    StLoad,
    StRead,
    StSend
  } state_e;

  state_e             state_q, state_d;
  rfzr_pkg::rows_t    rows_q, rows_d;
  logic [CW-1:0]      count_q, count_d;
  logic               dropped_q, dropped_d;
  logic [CW-1:0]      k_q, k_d;
  logic [JW-1:0]      j_q, j_d;
  rfzr_pkg::rows_t    r_q, r_d;
  rfzr_pkg::rows_t    rlast_q, rlast_d;
  rfzr_pkg::stride_t  step_q, step_d;
  rfzr_pkg::stride_t  cycle_q, cycle_d;
  logic               last_q, last_d;
  logic               ovf_q, ovf_d;

  rfzr_pkg::rows_t    rows_eff;
  rfzr_pkg::rows_t    r_nx;
  logic [CW-1:0]      n_new;
  logic               full;
  logic               ident;
  logic               in_acc;
  logic               out_acc;
  logic               edge_row;
  logic [JW-1:0]      sum;
  logic               ram_we;
  logic               ram_re;
  rfzr_pkg::char_t    ram_rdata;

  assign s_axis_tready = (state_q == StLoad);
  assign m_axis_tvalid = (state_q == StSend);
  assign m_axis_tdata  = ram_rdata;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_acc  = m_axis_tvalid && m_axis_tready;
  assign full     = (count_q == CW'(MAX_LEN));
  assign n_new    = full ? count_q : count_q + 1'b1;
  assign rows_eff = (rows_q == '0) ? rfzr_pkg::RowsW'(1) : rows_q;
  assign ident    = (rows_eff == rfzr_pkg::RowsW'(1)) || (JW'(n_new) < JW'(rows_eff));
  assign edge_row = (r_q == '0) || (r_q == rlast_q);
  assign r_nx     = r_q + 1'b1;
  assign sum      = j_q + JW'(step_q);
  assign ram_we   = in_acc && !full;
  assign ram_re   = (state_q == StRead);

  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    k_d       = k_q;
    j_d       = j_q;
    r_d       = r_q;
    rlast_d   = rlast_q;
    step_d    = step_q;
    cycle_d   = cycle_q;
    last_d    = last_q;
    ovf_d     = ovf_q;
    if (cfg_we_i) begin
      rows_d = cfg_wdata_i;
    end
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          count_d = n_new;
          if (full) begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast) begin
            k_d     = '0;
            j_d     = '0;
            r_d     = '0;
            cycle_d = ident ? rfzr_pkg::StrideW'(1)
                            : rfzr_pkg::StrideW'({rows_eff, 1'b0} - 8'd2);
            step_d  = ident ? rfzr_pkg::StrideW'(1)
                            : rfzr_pkg::StrideW'({rows_eff, 1'b0} - 8'd2);
            rlast_d = ident ? '0 : rows_eff - 1'b1;
            state_d = StRead;
          end
        end
      end
      StRead: begin
        last_d = (k_q == count_q - 1'b1);
        ovf_d  = dropped_q;
        k_d    = k_q + 1'b1;
        if (sum < JW'(count_q)) begin
          j_d    = sum;
          step_d = edge_row ? cycle_q : cycle_q - step_q;
        end else begin
          r_d    = r_nx;
          j_d    = JW'(r_nx);
          step_d = (r_nx == rlast_q) ? cycle_q
                                     : cycle_q - rfzr_pkg::StrideW'({r_nx, 1'b0});
        end
        state_d = StSend;
      end
      StSend: begin
        if (out_acc) begin
          if (last_q) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = StLoad;
          end else begin
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      rows_q    <= rfzr_pkg::RowsW'(1);
      count_q   <= '0;
      dropped_q <= 1'b0;
      k_q       <= '0;
      j_q       <= '0;
      r_q       <= '0;
      rlast_q   <= '0;
      step_q    <= '0;
      cycle_q   <= '0;
      last_q    <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      k_q       <= k_d;
      j_q       <= j_d;
      r_q       <= r_d;
      rlast_q   <= rlast_d;
      step_q    <= step_d;
      cycle_q   <= cycle_d;
      last_q    <= last_d;
      ovf_q     <= ovf_d;
    end
  end

  rfzr_ram #(
    .Width (rfzr_pkg::CharW),
    .Depth (MAX_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  `RFZR_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "load and send overlap")
  `RFZR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_LEN), "byte count past buffer size")
  `RFZR_ASSERT_NOW(a_read_in_range, state_q == StRead, j_q < JW'(count_q), "read beyond string")
  `RFZR_ASSERT_NEXT(a_last_returns, out_acc && m_axis_tlast, s_axis_tready && (count_q == '0),
                    "block not idle after final result")

endmodule

@@ rtl/rfzr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rfzr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/rail_fence_zigzag_checker.sv @@
// Checker that predicts the zigzag read-out of each string and compares the result stream.
`timescale 1ns / 1ps

module rail_fence_zigzag_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tlast,
  input  logic       m_axis_tuser,
  output int         fail_count_o,
  output int         pending_o,
  output int         result_count_o,
  output int         string_count_o
);

  typedef struct packed {
    rfzr_pkg::char_t ch;
    logic            last;
    logic            ovf;
  } zz_result_t;

  rfzr_pkg::rows_t rows_reg;
  rfzr_pkg::char_t line_buf [MAX_LEN];
  int              fill;
  logic            dropped;
  zz_result_t      zigzag_q [$];
  int              n_fail;
  int              n_results;
  int              n_strings;

  initial begin
    n_fail    = 0;
    n_results = 0;
    n_strings = 0;
  end

  assign fail_count_o   = n_fail;
  assign result_count_o = n_results;
  assign string_count_o = n_strings;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_fail++;
  endtask

  // Reads the buffered string out row by row and queues one result per byte.
  task automatic queue_zigzag();
    int         order [$];
    int         n;
    int         rails;
    int         period;
    int         pos;
    int         hop;
    int         row;
    zz_result_t res;
    n = fill;
    rails = (rows_reg == '0) ? 1 : int'(rows_reg);
    if (rails == 1 || n < rails) begin
      for (pos = 0; pos < n; pos++) order.push_back(pos);
    end else begin
      period = 2 * rails - 2;
      for (pos = 0; pos < n; pos += period) order.push_back(pos);
      for (row = 1; row < rails - 1; row++) begin
        hop = 2 * row;
        pos = row;
        while (pos < n) begin
          order.push_back(pos);
          hop = period - hop;
          pos += hop;
        end
      end
      for (pos = rails - 1; pos < n; pos += period) order.push_back(pos);
    end
    foreach (order[k]) begin
      res.ch   = line_buf[order[k]];
      res.last = (k == order.size() - 1);
      res.ovf  = dropped;
      zigzag_q.push_back(res);
    end
  endtask

  always @(posedge clk_i) begin
    zz_result_t want;
    if (!rst_ni) begin
      rows_reg = rfzr_pkg::rows_t'(1);
      fill     = 0;
      dropped  = 1'b0;
      zigzag_q.delete();
    end else begin
      if (cfg_we_i) rows_reg = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (zigzag_q.size() == 0) begin
          report($sformatf("result %02h arrived with nothing expected", m_axis_tdata));
        end else begin
          want = zigzag_q.pop_front();
          n_results++;
          if (m_axis_tdata !== want.ch)
            report($sformatf("out_char %02h, expected %02h", m_axis_tdata, want.ch));
          if (m_axis_tlast !== want.last)
            report($sformatf("out_last %b, expected %b", m_axis_tlast, want.last));
          if (m_axis_tuser !== want.ovf)
            report($sformatf("overflow %b, expected %b", m_axis_tuser, want.ovf));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fill < MAX_LEN) begin
          line_buf[fill] = s_axis_tdata;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          queue_zigzag();
          n_strings++;
          fill    = 0;
          dropped = 1'b0;
        end
      end
    end
    pending_o <= zigzag_q.size();
  end

endmodule

@@ bench/rail_fence_zigzag_reorder_tb.sv @@
// Top of the rail fence reorder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rail_fence_zigzag_reorder_tb;

  localparam int RandomItems = 420;
  localparam int PhaseItems  = 40;
  localparam int HoldCycles  = 400;
  localparam int RowsPlan [9] = '{1, 2, 3, 4, 5, 7, 64, 127, 0};

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [6:0] cfg_wdata_i   = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  int    fail_count;
  int    pending;
  int    result_count;
  int    string_count;
  int    gap_pct    = 0;
  int    stall_pct  = 0;
  int    hold_token = 0;
  int    hold_seen  = 0;
  int    hold_left  = 0;
  int    total_items = 0;
  int    n_settings  = 0;
  rfzr_pkg::char_t str_q [$];

  rail_fence_zigzag_reorder #(
    .MAX_LEN(64)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  rail_fence_zigzag_checker #(
    .MAX_LEN(64)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .string_count_o (string_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The receiver stalls at random, or for a long counted stretch when asked.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      m_axis_tready <= 1'b0;
      hold_seen     <= hold_token;
      hold_left     <= HoldCycles;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    gap_pct   = send_pct;
    stall_pct = recv_pct;
  endtask

  // Sends the bytes in str_q as one string, with tlast on the final byte.
  task automatic send_string();
    foreach (str_q[k]) begin
      while ($urandom_range(99) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= str_q[k];
      s_axis_tlast  <= (k == str_q.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      total_items++;
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_rows(input int value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rfzr_pkg::rows_t'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    #(40_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int start_items;
    int phase;
    int rows_v;
    int len;
    int pick;
    int phase_start;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle(0, 0);
    str_q = '{8'h00};
    send_string();
    str_q = '{8'hFF, 8'h55, 8'hAA};
    send_string();
    set_rows(3);
    str_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
    send_string();
    str_q = '{8'h10, 8'h20};
    send_string();
    set_rows(0);
    str_q = '{8'hA1, 8'hB2, 8'hC3};
    send_string();
    set_rows(2);
    str_q = '{8'h7F, 8'h80, 8'hFE, 8'h01};
    send_string();

    start_items = total_items;
    phase = 0;
    while (total_items - start_items < RandomItems) begin
      rows_v = (phase < 9) ? RowsPlan[phase] : $urandom_range(1, 127);
      set_rows(rows_v);
      case (phase % 4)
        0: set_idle(0, 0);
        1: set_idle(82, 0);
        2: set_idle(0, 82);
        default: set_idle(31, 31);
      endcase
      if (phase == 4) hold_token <= hold_token + 1;
      phase_start = total_items;
      while (total_items - phase_start < PhaseItems &&
             total_items - start_items < RandomItems) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          len = $urandom_range(64, 68);
        end else if (pick < 25) begin
          len = rows_v + $urandom_range(0, 2) - 1;
          if (len < 1) len = 1;
          if (len > 70) len = 70;
        end else begin
          len = $urandom_range(1, 16);
        end
        str_q.delete();
        repeat (len) str_q.push_back(rfzr_pkg::char_t'($urandom_range(255)));
        send_string();
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests in %0d strings over %0d row settings,",
             total_items, string_count, n_settings);
    $display("with all four idle mixes and a long receiver hold; %0d results checked.",
             result_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
